// ===== hdl/lqr_pkg.sv =====
`default_nettype none

package lqr_pkg;

  // Torque limit and settling count
  localparam int          U_MAX        = 65536;
  localparam logic [15:0] SETTLE_TICKS = 16'd500;

  // Operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  // End reasons
  localparam logic [2:0] REASON_NONE    = 3'd0;
  localparam logic [2:0] REASON_ENCODER = 3'd1;
  localparam logic [2:0] REASON_DRIVE   = 3'd2;
  localparam logic [2:0] REASON_AXIS    = 3'd3;
  localparam logic [2:0] REASON_TILT    = 3'd4;
  localparam logic [2:0] REASON_SPEED   = 3'd5;
  localparam logic [2:0] REASON_RAIL    = 3'd6;
  localparam logic [2:0] REASON_STOP    = 3'd7;

  // Configuration register indexes
  localparam logic [2:0] REG_GAIN_POSITION   = 3'd0;
  localparam logic [2:0] REG_GAIN_VELOCITY   = 3'd1;
  localparam logic [2:0] REG_GAIN_ANGLE      = 3'd2;
  localparam logic [2:0] REG_GAIN_ANGLE_RATE = 3'd3;
  localparam logic [2:0] REG_RAIL_LOW        = 3'd4;
  localparam logic [2:0] REG_RAIL_HIGH       = 3'd5;
  localparam logic [2:0] REG_ABORT_ANGLE     = 3'd6;
  localparam logic [2:0] REG_ABORT_SPEED     = 3'd7;

  // What the output stage does with the torque
  typedef enum logic [1:0] {
    KIND_HOLD,
    KIND_CLEAR,
    KIND_LAW
  } lqr_kind_t;

  typedef struct packed {
    lqr_kind_t  kind;
    logic       running;
    logic [2:0] reason;
    logic       pulse;
    logic       fault;
  } lqr_flags_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic               estimate_tick;
    logic               angle_fresh;
    logic               drive_fresh;
    logic               drive_error;
    logic               drive_closed_loop;
    logic signed [31:0] cart_pos;
    logic signed [31:0] cart_vel;
    logic signed [31:0] tilt;
    logic signed [31:0] tilt_rate;
  } lqr_in_t;

  typedef struct packed {
    logic signed [31:0] torque;
    logic               running;
    logic [2:0]         end_reason;
    logic               abort_pulse;
    logic               axis_fault;
  } lqr_out_t;

endpackage

`default_nettype wire

// ===== hdl/lqr_ctrl.sv =====
`default_nettype none

module lqr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire lqr_pkg::lqr_in_t   word,
  input  wire logic signed [31:0] rail_low,
  input  wire logic signed [31:0] rail_high,
  input  wire logic [30:0]        abort_angle,
  input  wire logic [30:0]        abort_speed,
  output lqr_pkg::lqr_flags_t     flags,
  output logic signed [31:0]      err,
  output logic signed [31:0]      vel,
  output logic signed [31:0]      ang,
  output logic signed [31:0]      ang_rate
);

  logic               active;
  logic [15:0]        tick_count;
  logic signed [31:0] target_pos;
  logic [2:0]         last_reason;

  logic               active_next;
  logic [15:0]        tick_count_next;
  logic signed [31:0] target_pos_next;
  logic [2:0]         last_reason_next;
  lqr_pkg::lqr_flags_t flags_next;

  logic [15:0]        tick_inc;
  logic signed [32:0] rail_sum;
  logic [31:0]        tilt_mag;
  logic [31:0]        vel_mag;
  logic [2:0]         why;
  logic signed [32:0] diff;
  logic signed [31:0] err_next;

  assign tick_inc = (tick_count != 16'hFFFF) ? tick_count + 16'd1 : tick_count;
  assign rail_sum = {rail_low[31], rail_low} + {rail_high[31], rail_high};
  assign tilt_mag = word.tilt[31] ? 32'(-word.tilt) : word.tilt;
  assign vel_mag  = word.cart_vel[31] ? 32'(-word.cart_vel) : word.cart_vel;

  // Checks in priority order, against the incremented tick count
  always_comb begin
    if (!word.angle_fresh) begin
      why = lqr_pkg::REASON_ENCODER;
    end else if (!word.drive_fresh) begin
      why = lqr_pkg::REASON_DRIVE;
    end else if (tick_inc > lqr_pkg::SETTLE_TICKS &&
                 (word.drive_error || !word.drive_closed_loop)) begin
      why = lqr_pkg::REASON_AXIS;
    end else if (tilt_mag > {1'b0, abort_angle}) begin
      why = lqr_pkg::REASON_TILT;
    end else if (vel_mag > {1'b0, abort_speed}) begin
      why = lqr_pkg::REASON_SPEED;
    end else if (word.cart_pos < rail_low || word.cart_pos > rail_high) begin
      why = lqr_pkg::REASON_RAIL;
    end else begin
      why = lqr_pkg::REASON_NONE;
    end
  end

  // Saturate the position error to 32 bits
  always_comb begin
    diff = {word.cart_pos[31], word.cart_pos} - {target_pos[31], target_pos};
    if (diff[32] != diff[31]) begin
      err_next = diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      err_next = diff[31:0];
    end
  end

  always_comb begin
    active_next      = active;
    tick_count_next  = tick_count;
    target_pos_next  = target_pos;
    last_reason_next = last_reason;
    flags_next.kind  = lqr_pkg::KIND_CLEAR;
    flags_next.pulse = 1'b0;
    flags_next.fault = 1'b0;
    case (word.operation)
      lqr_pkg::OP_START: begin
        target_pos_next  = rail_sum[32:1];
        tick_count_next  = '0;
        last_reason_next = lqr_pkg::REASON_NONE;
        active_next      = 1'b1;
      end
      lqr_pkg::OP_STOP: begin
        if (active) begin
          active_next      = 1'b0;
          last_reason_next = lqr_pkg::REASON_STOP;
        end
      end
      default: begin
        if (active) begin
          if (word.operation == lqr_pkg::OP_TICK && word.estimate_tick) begin
            tick_count_next = tick_inc;
            if (why != lqr_pkg::REASON_NONE) begin
              active_next      = 1'b0;
              last_reason_next = why;
              flags_next.pulse = 1'b1;
              flags_next.fault = why inside {lqr_pkg::REASON_DRIVE, lqr_pkg::REASON_AXIS};
            end else begin
              flags_next.kind = lqr_pkg::KIND_LAW;
            end
          end else begin
            flags_next.kind = lqr_pkg::KIND_HOLD;
          end
        end
      end
    endcase
    flags_next.running = active_next;
    flags_next.reason  = last_reason_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      tick_count  <= '0;
      target_pos  <= '0;
      last_reason <= lqr_pkg::REASON_NONE;
    end else if (load) begin
      active      <= active_next;
      tick_count  <= tick_count_next;
      target_pos  <= target_pos_next;
      last_reason <= last_reason_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      flags    <= flags_next;
      err      <= err_next;
      vel      <= word.cart_vel;
      ang      <= word.tilt;
      ang_rate <= word.tilt_rate;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lqr_mult.sv =====
`default_nettype none

module lqr_mult (
  input  wire logic                clk,
  input  wire logic                load,
  input  wire lqr_pkg::lqr_flags_t flags_in,
  input  wire logic signed [31:0]  err,
  input  wire logic signed [31:0]  vel,
  input  wire logic signed [31:0]  ang,
  input  wire logic signed [31:0]  ang_rate,
  input  wire logic signed [31:0]  gain_position,
  input  wire logic signed [31:0]  gain_velocity,
  input  wire logic signed [31:0]  gain_angle,
  input  wire logic signed [31:0]  gain_angle_rate,
  output lqr_pkg::lqr_flags_t      flags,
  output logic signed [63:0]       prod_pos,
  output logic signed [63:0]       prod_vel,
  output logic signed [63:0]       prod_ang,
  output logic signed [63:0]       prod_rate
);

  logic signed [63:0] prod_pos_next;
  logic signed [63:0] prod_vel_next;
  logic signed [63:0] prod_ang_next;
  logic signed [63:0] prod_rate_next;

  assign prod_pos_next  = gain_position * err;
  assign prod_vel_next  = gain_velocity * vel;
  assign prod_ang_next  = gain_angle * ang;
  assign prod_rate_next = gain_angle_rate * ang_rate;

  always_ff @(posedge clk) begin
    if (load) begin
      flags     <= flags_in;
      prod_pos  <= prod_pos_next;
      prod_vel  <= prod_vel_next;
      prod_ang  <= prod_ang_next;
      prod_rate <= prod_rate_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lqr_out.sv =====
`default_nettype none

module lqr_out (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire lqr_pkg::lqr_flags_t flags,
  input  wire logic signed [63:0]  prod_pos,
  input  wire logic signed [63:0]  prod_vel,
  input  wire logic signed [63:0]  prod_ang,
  input  wire logic signed [63:0]  prod_rate,
  output lqr_pkg::lqr_out_t        word
);

  localparam logic signed [66:0] LIMIT_HI = 67'(lqr_pkg::U_MAX);
  localparam logic signed [66:0] LIMIT_LO = -67'(lqr_pkg::U_MAX);

  logic signed [31:0] held_torque;
  logic signed [31:0] held_torque_next;
  logic signed [31:0] torque_next;
  logic signed [65:0] total;
  logic signed [66:0] scaled;
  logic signed [31:0] law;

  assign total = $signed({{2{prod_pos[63]}}, prod_pos}) + $signed({{2{prod_vel[63]}}, prod_vel})
               + $signed({{2{prod_ang[63]}}, prod_ang})
               + $signed({{2{prod_rate[63]}}, prod_rate});

  // Negate, then floor-scale by 2^16
  assign scaled = (67'sd0 - $signed({total[65], total})) >>> 16;

  always_comb begin
    if (scaled > LIMIT_HI) begin
      law = LIMIT_HI[31:0];
    end else if (scaled < LIMIT_LO) begin
      law = LIMIT_LO[31:0];
    end else begin
      law = scaled[31:0];
    end
  end

  always_comb begin
    case (flags.kind)
      lqr_pkg::KIND_HOLD: begin
        torque_next      = held_torque;
        held_torque_next = held_torque;
      end
      lqr_pkg::KIND_LAW: begin
        torque_next      = law;
        held_torque_next = law;
      end
      default: begin
        torque_next      = '0;
        held_torque_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_torque <= '0;
    end else if (load) begin
      held_torque <= held_torque_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word.torque      <= torque_next;
      word.running     <= flags.running;
      word.end_reason  <= flags.reason;
      word.abort_pulse <= flags.pulse;
      word.axis_fault  <= flags.fault;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lqr_balance_controller.sv =====
// A result word passes the input register, decision stage, product stage and output register.
// Throughput: one word per cycle while the output is not stalled;
// each stage moves on whenever the next is free.
// Run state updates as a word leaves the input register; held torque as it enters the output.
// Reset (rst, synchronous): config registers zero, run idle, held torque zero, pipe empty.
`default_nettype none

module lqr_balance_controller (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire lqr_pkg::lqr_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output lqr_pkg::lqr_out_t     out_data,
  input  wire logic             cfg_en,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [31:0]      cfg_data
);

  logic signed [31:0] gain_position;
  logic signed [31:0] gain_velocity;
  logic signed [31:0] gain_angle;
  logic signed [31:0] gain_angle_rate;
  logic signed [31:0] rail_low;
  logic signed [31:0] rail_high;
  logic [30:0]        abort_angle;
  logic [30:0]        abort_speed;

  lqr_pkg::lqr_in_t   in_q;
  logic               valid1;
  logic               valid2;
  logic               valid3;

  logic               free_out;
  logic               free3;
  logic               free2;
  logic               free1;
  logic               move1;
  logic               move2;
  logic               move3;

  lqr_pkg::lqr_flags_t flags2;
  lqr_pkg::lqr_flags_t flags3;
  logic signed [31:0] err;
  logic signed [31:0] vel;
  logic signed [31:0] ang;
  logic signed [31:0] ang_rate;
  logic signed [63:0] prod_pos;
  logic signed [63:0] prod_vel;
  logic signed [63:0] prod_ang;
  logic signed [63:0] prod_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_position   <= '0;
      gain_velocity   <= '0;
      gain_angle      <= '0;
      gain_angle_rate <= '0;
      rail_low        <= '0;
      rail_high       <= '0;
      abort_angle     <= '0;
      abort_speed     <= '0;
    end else if (cfg_en) begin
      case (cfg_index)
        lqr_pkg::REG_GAIN_POSITION:   gain_position   <= cfg_data;
        lqr_pkg::REG_GAIN_VELOCITY:   gain_velocity   <= cfg_data;
        lqr_pkg::REG_GAIN_ANGLE:      gain_angle      <= cfg_data;
        lqr_pkg::REG_GAIN_ANGLE_RATE: gain_angle_rate <= cfg_data;
        lqr_pkg::REG_RAIL_LOW:        rail_low        <= cfg_data;
        lqr_pkg::REG_RAIL_HIGH:       rail_high       <= cfg_data;
        lqr_pkg::REG_ABORT_ANGLE:     abort_angle     <= cfg_data[30:0];
        lqr_pkg::REG_ABORT_SPEED:     abort_speed     <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // A stage advances when the stage after it is empty or advancing
  assign free_out = !out_valid || !out_stall;
  assign move3    = valid3 && free_out;
  assign free3    = !valid3 || free_out;
  assign move2    = valid2 && free3;
  assign free2    = !valid2 || free3;
  assign move1    = valid1 && free2;
  assign free1    = !valid1 || free2;
  assign in_stall = !free1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      valid2    <= 1'b0;
      valid3    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (free1) valid1 <= in_valid;
      if (free2) valid2 <= valid1;
      if (free3) valid3 <= valid2;
      if (free_out) out_valid <= valid3;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && free1) begin
      in_q <= in_data;
    end
  end

  lqr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .load        (move1),
    .word        (in_q),
    .rail_low    (rail_low),
    .rail_high   (rail_high),
    .abort_angle (abort_angle),
    .abort_speed (abort_speed),
    .flags       (flags2),
    .err         (err),
    .vel         (vel),
    .ang         (ang),
    .ang_rate    (ang_rate)
  );

  lqr_mult u_mult (
    .clk             (clk),
    .load            (move2),
    .flags_in        (flags2),
    .err             (err),
    .vel             (vel),
    .ang             (ang),
    .ang_rate        (ang_rate),
    .gain_position   (gain_position),
    .gain_velocity   (gain_velocity),
    .gain_angle      (gain_angle),
    .gain_angle_rate (gain_angle_rate),
    .flags           (flags3),
    .prod_pos        (prod_pos),
    .prod_vel        (prod_vel),
    .prod_ang        (prod_ang),
    .prod_rate       (prod_rate)
  );

  lqr_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (move3),
    .flags     (flags3),
    .prod_pos  (prod_pos),
    .prod_vel  (prod_vel),
    .prod_ang  (prod_ang),
    .prod_rate (prod_rate),
    .word      (out_data)
  );

`ifndef SYNTHESIS
  a_abort_stops_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.abort_pulse |-> !out_data.running)
    else $error("abort word still shows the run active");

  a_fault_reason: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.axis_fault |-> out_data.abort_pulse &&
      (out_data.end_reason == lqr_pkg::REASON_DRIVE ||
       out_data.end_reason == lqr_pkg::REASON_AXIS))
    else $error("axis fault without a drive abort");

  a_running_no_reason: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.running |-> out_data.end_reason == lqr_pkg::REASON_NONE)
    else $error("active run carries an end reason");

  a_torque_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.torque <= 32'(lqr_pkg::U_MAX) &&
      out_data.torque >= -32'(lqr_pkg::U_MAX))
    else $error("torque beyond limit");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> valid1 && valid2 && valid3 && out_valid)
    else $error("input stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire

// ===== test/lqr_balance_controller_tb.sv =====
`timescale 1ns / 100ps

module testbench;
  import lqr_pkg::*;

  localparam logic [1:0]         OP_UNUSED = 2'd3;
  // estimate, angle fresh, drive fresh, drive error, closed loop
  localparam logic [4:0]         FRESH     = 5'b11101;
  localparam logic [4:0]         HELD      = 5'b01101;
  localparam logic [4:0]         NO_ANGLE  = 5'b10101;
  localparam logic [4:0]         NO_DRIVE  = 5'b11001;
  localparam logic [4:0]         UNSETTLED = 5'b11110;
  localparam logic [31:0]        ONE       = 32'h0001_0000;
  localparam logic [31:0]        MAX32     = 32'h7FFF_FFFF;
  localparam logic [31:0]        MIN32     = 32'h8000_0000;
  localparam logic signed [31:0] TQ_MAX    = U_MAX;
  localparam logic signed [31:0] TQ_MIN    = -U_MAX;
  localparam int                 IDLE_LIMIT = 4000;

  typedef struct {
    lqr_in_t  word;
    bit       typed;
    lqr_out_t result;
  } vector_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  lqr_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  lqr_out_t    out_data;
  logic        cfg_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  lqr_balance_controller uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_en(cfg_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Controller image: configuration and run state
  logic signed [31:0] k_pos = '0, k_vel = '0, k_ang = '0, k_rate = '0;
  logic signed [31:0] rail_lo = '0, rail_hi = '0;
  logic [30:0]        max_tilt = '0, max_speed = '0;
  bit                 run_active = 0;
  logic signed [31:0] target = '0, held = '0;
  logic [15:0]        fresh_ticks = '0;
  logic [2:0]         reason = REASON_NONE;

  lqr_out_t    pending_commands[$];
  lqr_out_t    due;
  vector_t     vectors[$];
  logic [31:0] settings[8];
  int words_sent = 0, results_seen = 0, mismatches = 0;
  int aborts_seen = 0, faults_seen = 0, clipped_seen = 0, settings_loaded = 0;
  int burst_left = 0, idle_cycles = 0;
  int hold_asked = 0, hold_served = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic lqr_out_t next_command(lqr_in_t w);
    lqr_out_t           r;
    logic [2:0]         why;
    logic signed [32:0] sum, gap_pos, mag_tilt, mag_vel;
    logic signed [31:0] pos_err;
    logic signed [67:0] acc, scaled;
    r = '0;
    if (w.operation == OP_START) begin
      sum = rail_lo + rail_hi;
      target = sum[32:1];
      held = '0;
      fresh_ticks = '0;
      reason = REASON_NONE;
      run_active = 1;
    end else if (w.operation == OP_STOP) begin
      if (run_active) begin
        run_active = 0;
        held = '0;
        reason = REASON_STOP;
      end
    end else if (run_active) begin
      if (w.operation != OP_TICK || !w.estimate_tick) begin
        r.torque = held;
      end else begin
        if (fresh_ticks != 16'hFFFF) fresh_ticks++;
        mag_tilt = w.tilt;
        if (mag_tilt < 0) mag_tilt = -mag_tilt;
        mag_vel = w.cart_vel;
        if (mag_vel < 0) mag_vel = -mag_vel;
        why = REASON_NONE;
        if (!w.angle_fresh) why = REASON_ENCODER;
        else if (!w.drive_fresh) why = REASON_DRIVE;
        else if (fresh_ticks > SETTLE_TICKS && (w.drive_error || !w.drive_closed_loop))
          why = REASON_AXIS;
        else if (mag_tilt > $signed({2'b00, max_tilt})) why = REASON_TILT;
        else if (mag_vel > $signed({2'b00, max_speed})) why = REASON_SPEED;
        else if (w.cart_pos < rail_lo || w.cart_pos > rail_hi) why = REASON_RAIL;
        if (why != REASON_NONE) begin
          run_active = 0;
          held = '0;
          reason = why;
          r.abort_pulse = 1'b1;
          r.axis_fault = (why == REASON_DRIVE || why == REASON_AXIS);
        end else begin
          gap_pos = w.cart_pos - target;
          if (gap_pos[32] != gap_pos[31]) pos_err = gap_pos[32] ? MIN32 : MAX32;
          else pos_err = gap_pos[31:0];
          acc = -(k_pos * pos_err + k_vel * w.cart_vel + k_ang * w.tilt
                  + k_rate * w.tilt_rate);
          scaled = acc >>> 16;
          if (scaled > U_MAX) r.torque = TQ_MAX;
          else if (scaled < -U_MAX) r.torque = TQ_MIN;
          else r.torque = scaled[31:0];
          held = r.torque;
        end
      end
    end
    r.running = run_active;
    r.end_reason = reason;
    return r;
  endfunction

  function automatic lqr_in_t row(logic [1:0] op, logic [4:0] flags, logic [31:0] pos,
                                  logic [31:0] vel, logic [31:0] tilt, logic [31:0] rate);
    lqr_in_t w;
    w.operation = op;
    {w.estimate_tick, w.angle_fresh, w.drive_fresh, w.drive_error,
     w.drive_closed_loop} = flags;
    w.cart_pos = pos;
    w.cart_vel = vel;
    w.tilt = tilt;
    w.tilt_rate = rate;
    return w;
  endfunction

  function automatic lqr_out_t cmd(logic [31:0] torque, logic running, logic [2:0] why,
                                   logic pulse, logic fault);
    lqr_out_t r;
    r.torque = torque;
    r.running = running;
    r.end_reason = why;
    r.abort_pulse = pulse;
    r.axis_fault = fault;
    return r;
  endfunction

  // Endpoints now and then, otherwise uniform over [lo, hi]
  function automatic logic [31:0] pick_in(longint lo, longint hi);
    longint unsigned span, r;
    if (lo > hi) return $urandom;
    case ($urandom_range(0, 15))
      0: return lo[31:0];
      1: return hi[31:0];
      default: begin
        span = hi - lo + 1;
        r = {$urandom, $urandom};
        return 32'(lo + longint'(r % span));
      end
    endcase
  endfunction

  function automatic lqr_in_t random_word();
    lqr_in_t w;
    w = {$urandom, $urandom, $urandom, $urandom, 7'($urandom)};
    return w;
  endfunction

  // Well-formed tick inside the current limits, with an occasional fault
  function automatic lqr_in_t balance_tick(int fault_pct);
    lqr_in_t w;
    w.operation = OP_TICK;
    w.estimate_tick = ($urandom_range(0, 9) != 0);
    w.angle_fresh = 1'b1;
    w.drive_fresh = 1'b1;
    w.drive_error = ($urandom_range(0, 5) == 0);
    w.drive_closed_loop = ($urandom_range(0, 5) != 0);
    w.cart_pos = pick_in(rail_lo, rail_hi);
    w.cart_vel = pick_in(-longint'(max_speed), longint'(max_speed));
    w.tilt = pick_in(-longint'(max_tilt), longint'(max_tilt));
    w.tilt_rate = $urandom_range(0, 1) ? $urandom : pick_in(-262144, 262144);
    if ($urandom_range(0, 99) < fault_pct) begin
      case ($urandom_range(0, 4))
        0: w.angle_fresh = 1'b0;
        1: w.drive_fresh = 1'b0;
        2: w.tilt = MIN32;
        3: w.cart_vel = MIN32;
        default: begin
          if (rail_lo != $signed(MIN32)) w.cart_pos = rail_lo - 1;
          else if (rail_hi != $signed(MAX32)) w.cart_pos = rail_hi + 1;
        end
      endcase
    end
    return w;
  endfunction

  task automatic send_word(input lqr_in_t w, input bit typed, input lqr_out_t fixed);
    lqr_out_t predicted;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    predicted = next_command(w);
    pending_commands.push_back(typed ? fixed : predicted);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  // Drop valid and hold until every command is back, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    while (results_seen != words_sent) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic load_settings();
    int i;
    for (i = 0; i < 8; i++) begin
      cfg_en <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= settings[i];
      @(posedge clk);
      case (3'(i))
        REG_GAIN_POSITION:   k_pos = settings[i];
        REG_GAIN_VELOCITY:   k_vel = settings[i];
        REG_GAIN_ANGLE:      k_ang = settings[i];
        REG_GAIN_ANGLE_RATE: k_rate = settings[i];
        REG_RAIL_LOW:        rail_lo = settings[i];
        REG_RAIL_HIGH:       rail_hi = settings[i];
        REG_ABORT_ANGLE:     max_tilt = settings[i][30:0];
        REG_ABORT_SPEED:     max_speed = settings[i][30:0];
        default: ;
      endcase
    end
    cfg_en <= 1'b0;
    settings_loaded++;
  endtask

  task automatic run_mix(int words, bit with_hold);
    lqr_in_t w;
    int first;
    first = words_sent;
    if (with_hold) hold_asked++;
    while (words_sent - first < words) begin
      if ($urandom_range(0, 7) == 0) begin
        send_word(random_word(), 0, '0);
      end else begin
        w = random_word();
        w.operation = OP_START;
        send_word(w, 0, '0);
        repeat ($urandom_range(2, 25)) send_word(balance_tick(4), 0, '0);
        if ($urandom_range(0, 1)) begin
          w = random_word();
          w.operation = OP_STOP;
          send_word(w, 0, '0);
        end
      end
    end
  endtask

  // Receiver: own stall pattern, plus a long hold-off on request
  initial begin
    int mode, hold_left, cyc;
    mode = 0;
    hold_left = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 50 == 0) mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        hold_left = 80;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          2: out_stall <= (cyc % 7 < 3);
          default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_commands.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word torque %0d reason %0d", $time,
                 $signed(out_data.torque), out_data.end_reason);
      end else begin
        due = pending_commands.pop_front();
        if (out_data.torque !== due.torque || out_data.running !== due.running ||
            out_data.end_reason !== due.end_reason ||
            out_data.abort_pulse !== due.abort_pulse ||
            out_data.axis_fault !== due.axis_fault) begin
          mismatches++;
          if (mismatches <= 40)
            $display("%0t: expected torque %0d run %0b reason %0d abort %0b fault %0b, got %s",
                     $time, $signed(due.torque), due.running, due.end_reason,
                     due.abort_pulse, due.axis_fault,
                     $sformatf("torque %0d run %0b reason %0d abort %0b fault %0b",
                               $signed(out_data.torque), out_data.running,
                               out_data.end_reason, out_data.abort_pulse,
                               out_data.axis_fault));
        end
        if (due.abort_pulse) aborts_seen++;
        if (due.axis_fault) faults_seen++;
        if (due.torque == TQ_MAX || due.torque == TQ_MIN) clipped_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("[lqr_balance_controller] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    lqr_in_t w;
    int i;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    settings[REG_GAIN_POSITION] = ONE;
    settings[REG_GAIN_VELOCITY] = 32'h0000_8000;
    settings[REG_GAIN_ANGLE] = 32'hFFFE_0000;
    settings[REG_GAIN_ANGLE_RATE] = MAX32;
    settings[REG_RAIL_LOW] = 32'hFFFB_0000;
    settings[REG_RAIL_HIGH] = 32'h0005_0000;
    settings[REG_ABORT_ANGLE] = ONE;
    settings[REG_ABORT_SPEED] = 32'h0002_0000;
    load_settings();

    vectors.push_back('{row(OP_TICK, FRESH, 0, 0, 0, 0), 1,
                        cmd(0, 0, REASON_NONE, 0, 0)});
    vectors.push_back('{row(OP_STOP, FRESH, 0, 0, 0, 0), 1,
                        cmd(0, 0, REASON_NONE, 0, 0)});
    vectors.push_back('{row(OP_UNUSED, FRESH, 0, 0, 0, 0), 1,
                        cmd(0, 0, REASON_NONE, 0, 0)});
    vectors.push_back('{row(OP_START, FRESH, 0, 0, 0, 0), 1,
                        cmd(0, 1, REASON_NONE, 0, 0)});
    vectors.push_back('{row(OP_START, HELD, MAX32, MIN32, 0, 0), 1,
                        cmd(0, 1, REASON_NONE, 0, 0)});
    // axis flags are ignored until the settling count has passed
    vectors.push_back('{row(OP_TICK, UNSETTLED, 0, 0, 0, 0), 1,
                        cmd(0, 1, REASON_NONE, 0, 0)});
    vectors.push_back('{row(OP_TICK, FRESH, ONE, 32'h0000_8000, 0, 0), 0, '0});
    vectors.push_back('{row(OP_TICK, HELD, MAX32, MAX32, MAX32, MAX32), 0, '0});
    vectors.push_back('{row(OP_UNUSED, FRESH, 0, 0, 0, 0), 0, '0});
    vectors.push_back('{row(OP_TICK, FRESH, 0, 0, 0, MAX32), 1,
                        cmd(TQ_MIN, 1, REASON_NONE, 0, 0)});
    vectors.push_back('{row(OP_TICK, FRESH, 0, 0, 0, MIN32), 1,
                        cmd(TQ_MAX, 1, REASON_NONE, 0, 0)});
    vectors.push_back('{row(OP_TICK, FRESH, 32'hFFFB_0000, 32'hFFFE_0000,
                            32'hFFFF_0000, 32'h0000_0123), 0, '0});
    vectors.push_back('{row(OP_TICK, HELD, 0, 0, 0, 0), 0, '0});
    // encoder check wins over a tilt that is also out of range
    vectors.push_back('{row(OP_TICK, NO_ANGLE, 0, 0, MIN32, 0), 1,
                        cmd(0, 0, REASON_ENCODER, 1, 0)});
    vectors.push_back('{row(OP_TICK, HELD, 0, 0, 0, 0), 1,
                        cmd(0, 0, REASON_ENCODER, 0, 0)});
    vectors.push_back('{row(OP_START, FRESH, 0, 0, 0, 0), 1,
                        cmd(0, 1, REASON_NONE, 0, 0)});
    vectors.push_back('{row(OP_TICK, NO_DRIVE, 0, 0, 0, 0), 1,
                        cmd(0, 0, REASON_DRIVE, 1, 1)});
    vectors.push_back('{row(OP_START, FRESH, 0, 0, 0, 0), 1,
                        cmd(0, 1, REASON_NONE, 0, 0)});
    vectors.push_back('{row(OP_TICK, FRESH, 0, 0, MIN32, 0), 1,
                        cmd(0, 0, REASON_TILT, 1, 0)});
    vectors.push_back('{row(OP_START, FRESH, 0, 0, 0, 0), 1,
                        cmd(0, 1, REASON_NONE, 0, 0)});
    vectors.push_back('{row(OP_TICK, FRESH, MAX32, 32'h0002_0001, 0, 0), 1,
                        cmd(0, 0, REASON_SPEED, 1, 0)});
    vectors.push_back('{row(OP_START, FRESH, 0, 0, 0, 0), 1,
                        cmd(0, 1, REASON_NONE, 0, 0)});
    vectors.push_back('{row(OP_TICK, FRESH, 32'h0005_0001, 0, 0, 0), 1,
                        cmd(0, 0, REASON_RAIL, 1, 0)});
    vectors.push_back('{row(OP_START, FRESH, 0, 0, 0, 0), 1,
                        cmd(0, 1, REASON_NONE, 0, 0)});
    vectors.push_back('{row(OP_STOP, FRESH, 0, 0, 0, 0), 1,
                        cmd(0, 0, REASON_STOP, 0, 0)});
    vectors.push_back('{row(OP_STOP, FRESH, 0, 0, 0, 0), 1,
                        cmd(0, 0, REASON_STOP, 0, 0)});
    foreach (vectors[i]) send_word(vectors[i].word, vectors[i].typed, vectors[i].result);
    settle();

    // full-range gains, widest rails, loosest limits; long output hold-off
    for (i = 0; i < 4; i++) settings[i] = $urandom;
    settings[REG_RAIL_LOW] = MIN32;
    settings[REG_RAIL_HIGH] = MAX32;
    settings[REG_ABORT_ANGLE] = 32'hFFFF_FFFF;
    settings[REG_ABORT_SPEED] = 32'hFFFF_FFFF;
    load_settings();
    run_mix(25, 1);
    settle();

    // moderate gains and limits, so aborts come often
    for (i = 0; i < 4; i++) settings[i] = pick_in(-262144, 262144);
    settings[REG_RAIL_LOW] = pick_in(-1048576, 0);
    settings[REG_RAIL_HIGH] = pick_in(0, 1048576);
    settings[REG_ABORT_ANGLE] = {1'($urandom), 31'(pick_in(4096, 262144))};
    settings[REG_ABORT_SPEED] = {1'($urandom), 31'(pick_in(4096, 262144))};
    load_settings();
    run_mix(25, 0);
    settle();

    // degenerate: most negative gains, crossed rails, zero limits
    for (i = 0; i < 4; i++) settings[i] = MIN32;
    settings[REG_RAIL_LOW] = MAX32;
    settings[REG_RAIL_HIGH] = MIN32;
    settings[REG_ABORT_ANGLE] = 32'h0;
    settings[REG_ABORT_SPEED] = 32'h8000_0000;
    load_settings();
    run_mix(10, 0);
    settle();

    // one run long enough to pass the settling count, then axis checks apply
    for (i = 0; i < 4; i++) settings[i] = pick_in(-131072, 131072);
    settings[REG_RAIL_LOW] = 32'hFFC0_0000;
    settings[REG_RAIL_HIGH] = 32'h0040_0000;
    settings[REG_ABORT_ANGLE] = 32'h0003_0000;
    settings[REG_ABORT_SPEED] = 32'h0003_0000;
    load_settings();
    w = random_word();
    w.operation = OP_START;
    send_word(w, 0, '0);
    for (i = 0; i < 525; i++) begin
      w = balance_tick(i < 500 ? 0 : 3);
      if (i < 500) w.estimate_tick = 1'b1;
      send_word(w, 0, '0);
    end
    send_word(row(OP_STOP, FRESH, 0, 0, 0, 0), 0, '0);
    settle();

    repeat (8) @(posedge clk);
    if (pending_commands.size() != 0) begin
      mismatches++;
      $display("%0t: %0d commands never came out", $time, pending_commands.size());
    end
    $display("Checked %0d results from %0d words over %0d register settings:", results_seen,
             words_sent, settings_loaded);
    $display("  %0d aborts (%0d drive faults), %0d torques clipped at the limit",
             aborts_seen, faults_seen, clipped_seen);
    if (mismatches == 0) begin
      $display("[lqr_balance_controller] OK");
    end else begin
      $display("[lqr_balance_controller] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/lqr_pkg.sv
hdl/lqr_ctrl.sv
hdl/lqr_mult.sv
hdl/lqr_out.sv
hdl/lqr_balance_controller.sv
test/lqr_balance_controller_tb.sv
